// File: hdl/cu_pkg.sv
// cu_pkg: shared types, widths and the binomial coefficient table for
// the combination unranking block. No dependencies.
package cu_pkg;

   localparam int MAX_N = 16;
   localparam int MAX_K = 9;

   // field widths of the request and result items
   localparam int RANK_W = 14;
   localparam int SIZE_W = 4;
   localparam int ELEM_W = 4;
   localparam int POS_W  = 4;

   // slot counter and candidate index widths
   localparam int SLOT_W = $clog2(MAX_K + 1);
   localparam int IDX_W  = $clog2(MAX_N + 1);

   // coefficients saturate at 2**RANK_W, which is above any rank
   localparam int BINOM_W   = RANK_W + 1;
   localparam int BINOM_SAT = 2 ** RANK_W;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [SIZE_W-1:0] subset_size;
   } cu_req_type;

   typedef struct packed {
      logic [ELEM_W-1:0] element;
      logic [POS_W-1:0]  position;
      logic              last_item;
      logic              out_of_range;
   } cu_rsp_type;

   // work item travelling down the chain
   typedef struct packed {
      logic              valid;
      logic              oor;
      logic [RANK_W-1:0] rem;
      logic [SLOT_W-1:0] slots;
   } cu_token_type;

   // result produced by a cell
   typedef struct packed {
      logic       valid;
      cu_rsp_type rsp;
   } cu_emit_type;

   typedef logic [MAX_N:0][MAX_K:0][BINOM_W-1:0] binom_table_type;

   // pascal triangle, saturated
   function automatic binom_table_type build_binom();
      binom_table_type tbl;
      int sum;
      tbl = '0;
      for (int n = 0; n <= MAX_N; n++) begin
         tbl[n][0] = BINOM_W'(1);
         for (int j = 1; j <= MAX_K; j++) begin
            if (n > 0) begin
               sum = int'(tbl[n-1][j-1]) + int'(tbl[n-1][j]);
               tbl[n][j] = (sum > BINOM_SAT) ? BINOM_W'(BINOM_SAT) : BINOM_W'(sum);
            end
         end
      end
      return tbl;
   endfunction

   localparam binom_table_type BINOM_TBL = build_binom();

endpackage

// File: hdl/cu_cell.sv
// cu_cell: one candidate cell of the unranking chain; tests the passing
// token against C(cand, slots). Depends on cu_pkg.
module cu_cell import cu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [IDX_W-1:0]  cand,
   input  cu_token_type      tok_in,
   output cu_token_type      tok_out,
   output cu_emit_type       emit,
   output logic              busy
);

   logic              valid_ff;
   logic              oor_ff;
   logic [RANK_W-1:0] rem_ff;
   logic [SLOT_W-1:0] slots_ff;

   logic [BINOM_W-1:0] coef;
   logic               fits;
   logic               hit;
   logic               final_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= tok_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         oor_ff   <= tok_in.oor;
         rem_ff   <= tok_in.rem;
         slots_ff <= tok_in.slots;
      end
   end

   always_comb begin
      coef      = BINOM_TBL[cand][slots_ff];
      fits      = coef <= {1'b0, rem_ff};
      hit       = valid_ff && (oor_ff || ((slots_ff != '0) && fits));
      final_hit = hit && (oor_ff || (slots_ff == SLOT_W'(1)));

      emit.valid = hit;
      if (hit && !oor_ff) begin
         emit.rsp.element  = ELEM_W'(cand);
         emit.rsp.position = POS_W'(slots_ff - SLOT_W'(1));
      end else begin
         emit.rsp.element  = '0;
         emit.rsp.position = '0;
      end
      emit.rsp.last_item    = final_hit;
      emit.rsp.out_of_range = hit && oor_ff;

      tok_out.valid = valid_ff && !final_hit;
      tok_out.oor   = oor_ff;
      tok_out.rem   = hit ? (rem_ff - coef[RANK_W-1:0]) : rem_ff;
      tok_out.slots = hit ? (slots_ff - SLOT_W'(1)) : slots_ff;
   end

   assign busy = valid_ff;

endmodule

// File: hdl/combination_unrank.sv
// combination_unrank: top level of the combinadic unranking block.
// Depends on cu_pkg and cu_cell.
//
// Takes a rank and a subset size k and returns the k-element combination of
// 0..MAX_N-1 with that colexicographic rank, one result per element, largest
// element first, position counting down from k-1 to 0, last_item on the final
// one. A size of zero, a size above MAX_K or a rank at or above C(MAX_N,k)
// gives a single result with out_of_range and last_item set, element and
// position zero. Inside, a request becomes a token that walks a row of MAX_N
// cells, one cell per cycle while the chain advances, from candidate MAX_N-1
// down to 0; a cell emits its candidate when C(candidate, slots left) fits in
// the remaining rank and subtracts it. One request is in the chain at a time:
// the token leaves the row at the cell of its smallest element, or at the
// first cell for an out-of-range request, and only then is a new request
// taken. Results leave through an output register, so a new request is taken
// while the last result of the previous one still waits.
module combination_unrank import cu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  cu_req_type req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cu_rsp_type rsp_data
);

   // request decode and range check
   logic               size_ok;
   logic [BINOM_W-1:0] rank_limit;
   logic               rank_ok;
   cu_token_type       req_tok;

   // chain of cells
   cu_token_type       tok_link [MAX_N];
   cu_emit_type        emit_vec [MAX_N];
   logic [MAX_N-1:0]   busy_vec;
   logic               chain_busy;
   logic               advance;

   // selected result and output register
   logic               emit_valid;
   cu_rsp_type         rsp_sel;
   logic               rsp_valid_ff;
   cu_rsp_type         rsp_data_ff;

   // size must be 1..MAX_K, rank below C(MAX_N, k)
   always_comb begin
      size_ok    = (req_data.subset_size != '0) && (32'(req_data.subset_size) <= MAX_K);
      rank_limit = size_ok ? BINOM_TBL[MAX_N][SLOT_W'(req_data.subset_size)] : '0;
      rank_ok    = {1'b0, req_data.rank} < rank_limit;

      req_tok.valid = req_valid && req_ready;
      req_tok.oor   = !(size_ok && rank_ok);
      req_tok.rem   = req_data.rank;
      req_tok.slots = SLOT_W'(req_data.subset_size);
   end

   // one request in flight: take a new one only with the chain empty
   assign chain_busy = |busy_vec;
   assign req_ready  = !chain_busy;

   // the chain moves unless a cell has a result and the output is full and not taken
   assign advance = !emit_valid || !rsp_valid_ff || rsp_ready;

   // cell 0 tests candidate MAX_N-1, the last cell tests candidate 0
   for (genvar i = 0; i < MAX_N; i++) begin : g_cell
      cu_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .cand    (IDX_W'(MAX_N - 1 - i)),
         .tok_in  ((i == 0) ? req_tok : tok_link[(i == 0) ? 0 : i - 1]),
         .tok_out (tok_link[i]),
         .emit    (emit_vec[i]),
         .busy    (busy_vec[i])
      );
   end

   // at most one cell holds the token, so at most one emits
   always_comb begin
      emit_valid = 1'b0;
      rsp_sel    = '0;
      for (int i = 0; i < MAX_N; i++) begin
         if (emit_vec[i].valid) begin
            emit_valid = 1'b1;
            rsp_sel    = emit_vec[i].rsp;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit_valid) begin
         rsp_data_ff <= rsp_sel;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the token always finishes by candidate 0 and never leaves the row
   a_no_runoff : assert property (@(posedge clock) disable iff (reset)
      !tok_link[MAX_N-1].valid)
      else $error("token ran off the end of the cell chain");

   // only one request is ever in the chain
   a_single_token : assert property (@(posedge clock) disable iff (reset)
      $onehot0(busy_vec))
      else $error("more than one cell holds a token");

   // once the final result is taken into the output register the chain is empty
   a_last_drains : assert property (@(posedge clock) disable iff (reset)
      (advance && emit_valid && rsp_sel.last_item) |=> !chain_busy)
      else $error("chain still busy after the final result");

   // an out-of-range result is a lone final result with zero fields
   a_oor_shape : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.out_of_range) |->
         (rsp_data_ff.last_item && rsp_data_ff.element == '0 &&
          rsp_data_ff.position == '0))
      else $error("malformed out-of-range result");

endmodule

// File: verif/tb_combination_unrank.sv
// tb_combination_unrank: self-checking testbench for the combinadic unranking block
// depends on cu_pkg and combination_unrank; predicts every result item locally
// and checks each one in order, under several idle mixes and a long output stall
module tb_combination_unrank;
   import cu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 2 * MAX_N + 8;
   localparam int RANK_MAX     = 2 ** RANK_W - 1;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   cu_req_type req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   cu_rsp_type rsp_data;

   // results still owed by the block, oldest first
   cu_rsp_type expected_elements[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asked    = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   int cycle_count    = 0;
   int mismatches     = 0;
   int requests_sent  = 0;
   int oor_requests   = 0;
   int results_seen   = 0;

   combination_unrank uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // exact binomial coefficient, zero when j > n
   function automatic int choose(input int n, input int j);
      longint acc;
      acc = 1;
      if (j > n) begin
         return 0;
      end
      for (int i = 1; i <= j; i++) begin
         acc = (acc * longint'(n - j + i)) / longint'(i);
      end
      return int'(acc);
   endfunction

   // greedy combinadic walk: largest element first, one result per slot
   function automatic void unrank_expected(input cu_req_type item);
      int         k;
      int         remaining;
      int         c;
      cu_rsp_type res;
      k = int'(item.subset_size);
      remaining = int'(item.rank);
      if (k == 0 || k > MAX_K || remaining >= choose(MAX_N, k)) begin
         res = '0;
         res.last_item = 1'b1;
         res.out_of_range = 1'b1;
         expected_elements.push_back(res);
         oor_requests++;
         return;
      end
      for (int j = k; j >= 1; j--) begin
         c = j - 1;
         while (c + 1 < MAX_N && choose(c + 1, j) <= remaining) begin
            c++;
         end
         remaining -= choose(c, j);
         res.element = ELEM_W'(c);
         res.position = POS_W'(j - 1);
         res.last_item = (j == 1);
         res.out_of_range = 1'b0;
         expected_elements.push_back(res);
      end
   endfunction

   function automatic cu_req_type make_request(input int rank, input int size);
      cu_req_type item;
      item.rank = RANK_W'(rank);
      item.subset_size = SIZE_W'(size);
      return item;
   endfunction

   // mostly legal ranks for a legal size, some ranks past the bound, some bad sizes
   function automatic cu_req_type random_request();
      int pick;
      int k;
      int v;
      pick = $urandom_range(99);
      k = $urandom_range(MAX_K, 1);
      if (pick < 85) begin
         return make_request($urandom_range(choose(MAX_N, k) - 1, 0), k);
      end else if (pick < 93) begin
         return make_request($urandom_range(RANK_MAX, choose(MAX_N, k)), k);
      end
      v = $urandom_range(2 ** SIZE_W - 1 - MAX_K, 0);
      return make_request($urandom_range(RANK_MAX, 0), (v == 0) ? 0 : v + MAX_K);
   endfunction

   // offer one request after a random gap and wait for the handshake
   task automatic send_request(input cu_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      unrank_expected(item);
      requests_sent++;
   endtask

   // drop valid and let every owed result come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_elements.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // first or last legal rank of each size, past-bound ranks, bad sizes, max element and position
   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_request(make_request(0, 1));
      send_request(make_request(15, 1));
      send_request(make_request(16, 1));
      send_request(make_request(RANK_MAX, 1));
      send_request(make_request(0, MAX_K));
      send_request(make_request(choose(MAX_N, MAX_K) - 1, MAX_K));
      send_request(make_request(choose(MAX_N, MAX_K), MAX_K));
      send_request(make_request(choose(MAX_N, 8) - 1, 8));
      send_request(make_request(choose(MAX_N, 8), 8));
      send_request(make_request(0, 0));
      send_request(make_request(5, MAX_K + 1));
      send_request(make_request(RANK_MAX, 2 ** SIZE_W - 1));
      send_request(make_request(119, 2));
      send_request(make_request(0, 3));
      send_request(make_request(1819, 4));
      send_request(make_request(4367, 5));
      send_request(make_request(8007, 6));
      send_request(make_request(11439, 7));
      wait_drained();
   endtask

   task automatic test_random(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) begin
         send_request(random_request());
      end
      wait_drained();
   endtask

   // output held off for a long stretch while full-size requests keep coming
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_asked++;
      repeat (20) begin
         send_request(make_request($urandom_range(choose(MAX_N, MAX_K) - 1, 0), MAX_K));
      end
      wait_drained();
   endtask

   // receiver: random ready, or a long hold when one is asked for
   always @(posedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t mismatch on %s: expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // result checker: every accepted result against the oldest expectation
   always @(posedge clock) begin
      cu_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_elements.size() == 0) begin
            $display("%0t unexpected result: expected none actual elem %0d pos %0d last %0b oor %0b",
                     $time, rsp_data.element, rsp_data.position, rsp_data.last_item,
                     rsp_data.out_of_range);
            mismatches++;
         end else begin
            want = expected_elements.pop_front();
            check_field("element", want.element, rsp_data.element);
            check_field("position", want.position, rsp_data.position);
            check_field("last_item", want.last_item, rsp_data.last_item);
            check_field("out_of_range", want.out_of_range, rsp_data.out_of_range);
         end
      end
   end

   // watchdog on a hung handshake
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time, expected_elements.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(78, 30, 68);
      test_random(78, 68, 30);
      test_random(78, 0, 0);
      test_backpressure();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests (%0d out of range) giving %0d results",
               requests_sent, oor_requests, results_seen);
      $display("under three idle mixes, a %0d-cycle output hold and drain pauses", HOLD_CYCLES);
      if (mismatches == 0 && expected_elements.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/cu_pkg.sv
hdl/cu_cell.sv
hdl/combination_unrank.sv
verif/tb_combination_unrank.sv
